[hdl/preemptive_priority_scheduler_assert.svh]
// Assertion macros for the preemptive priority scheduler.
// Used inside modules that have clk and rst_n; compiled away when SYNTH is set.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`ifndef SYNTH
`define PPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/pps_pkg.sv]
// Shared constants and types of the preemptive priority scheduler.
// No dependencies.
package pps_pkg;

    localparam int DEF_MAX_PROCESSES = 64;
    localparam int DEF_TIME_BITS     = 16;

    localparam int CFG_W    = 7;
    localparam int SLOT_W   = 6;
    localparam int ARRIVE_W = 16;
    localparam int PRIO_W   = 8;
    localparam int BURST_W  = 16;
    localparam int FIN_W    = 7;

    localparam logic [FIN_W-1:0] FINISH_MAX = 7'd127;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic [ARRIVE_W-1:0] arrival;
        logic [PRIO_W-1:0]   prio;
        logic [BURST_W-1:0]  remaining;
    } pps_entry_t;

endpackage

[hdl/pps_if.sv]
// Valid/ready channel interfaces for scheduler input and result beats.
// Depends on pps_pkg for field widths.
interface pps_in_if;
    import pps_pkg::*;
    logic                valid;
    logic                ready;
    logic                action;
    logic [SLOT_W-1:0]   slot;
    logic [ARRIVE_W-1:0] arrival_time;
    logic [PRIO_W-1:0]   priority_req;
    logic [BURST_W-1:0]  burst_time;

    modport source (output valid, action, slot, arrival_time, priority_req, burst_time,
                    input ready);
    modport sink   (input valid, action, slot, arrival_time, priority_req, burst_time,
                    output ready);
endinterface

interface pps_out_if;
    import pps_pkg::*;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] chosen_slot;
    logic              idle;
    logic              completed;
    logic              switched;
    logic              all_done;

    modport source (output valid, chosen_slot, idle, completed, switched, all_done,
                    input ready);
    modport sink   (input valid, chosen_slot, idle, completed, switched, all_done,
                    output ready);
endinterface

[hdl/pps_table.sv]
// Process table memory: one write port, one read port with registered data.
// Depends on pps_pkg for the entry type.
module pps_table #(
    parameter int DEPTH = pps_pkg::DEF_MAX_PROCESSES,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  pps_pkg::pps_entry_t wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output pps_pkg::pps_entry_t rd_data
);
    import pps_pkg::*;

    pps_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler: a load beat writes one table entry.
// A tick beat scans the table one slot a cycle through a single compare unit fed by
// the table's one read port, over min(process_count, MAX_PROCESSES) slots; no new beat
// is accepted until the tick's result is registered, and a stalled result beat holds
// the next tick in DECIDE. Reset clears time, finished count, previous slot and
// process_count; table entries must be loaded before a tick scans.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCESSES = pps_pkg::DEF_MAX_PROCESSES,
    parameter int TIME_BITS     = pps_pkg::DEF_TIME_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    pps_in_if.sink                    sched_in,
    pps_out_if.source                 sched_out,
    input  logic                      cfg_we,
    input  logic [pps_pkg::CFG_W-1:0] cfg_wdata
);
    import pps_pkg::*;

`include "preemptive_priority_scheduler_assert.svh"

    localparam int ADDR_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int CMP_W  = (TIME_BITS > ARRIVE_W) ? TIME_BITS : ARRIVE_W;
    localparam int EQ_W   = (CNT_W > FIN_W) ? CNT_W : FIN_W;

    // SCAN issues one table read a cycle, DRAIN compares the last one,
    // DECIDE serves the winner and loads the result register.
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DECIDE} state_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    pc_reg, pc_next;
    logic [TIME_BITS-1:0] tick_reg, tick_next;
    logic [FIN_W-1:0]    fin_reg, fin_next;
    logic                prev_idle_reg, prev_idle_next;
    logic [ADDR_W-1:0]   prev_slot_reg, prev_slot_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [ADDR_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                found_reg, found_next;
    pps_entry_t          best_reg, best_next;
    logic [ADDR_W-1:0]   best_idx_reg, best_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_idle_reg, out_idle_next;
    logic                out_completed_reg, out_completed_next;
    logic                out_switched_reg, out_switched_next;
    logic                out_all_done_reg, out_all_done_next;

    logic [CNT_W-1:0]    count_eff;
    logic [CNT_W-1:0]    k_inc;
    logic                in_acc;
    logic                out_free;
    logic                eligible;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    pps_entry_t          wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    pps_entry_t          rd_data;
    logic [BURST_W-1:0]  new_rem;
    logic                done_now;
    logic [FIN_W-1:0]    fin_upd;

    pps_table #(
        .DEPTH (MAX_PROCESSES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Clamp the slot count to the table depth.
    assign count_eff = (32'(pc_reg) > MAX_PROCESSES) ? CNT_W'(MAX_PROCESSES) : CNT_W'(pc_reg);
    assign k_inc     = k_reg + CNT_W'(1);

    assign sched_in.ready = (state_reg == S_IDLE);
    assign in_acc         = sched_in.valid && sched_in.ready;
    assign out_free       = !out_valid_reg || sched_out.ready;

    assign rd_en   = (state_reg == S_SCAN);
    assign rd_addr = k_reg[ADDR_W-1:0];

    // Shared compare unit: one table entry per cycle against the running best.
    // Strict greater-than keeps the lowest slot on a priority tie.
    assign eligible = rd_valid_reg
                   && (CMP_W'(rd_data.arrival) <= CMP_W'(tick_reg))
                   && (rd_data.remaining != '0)
                   && (!found_reg || (rd_data.prio > best_reg.prio));

    // Serve the winner: decrement its burst and count a completion.
    assign new_rem  = best_reg.remaining - BURST_W'(1);
    assign done_now = found_reg && (new_rem == '0);
    assign fin_upd  = (done_now && (fin_reg < FINISH_MAX)) ? fin_reg + FIN_W'(1) : fin_reg;

    always_comb
    begin
        state_next         = state_reg;
        pc_next            = pc_reg;
        tick_next          = tick_reg;
        fin_next           = fin_reg;
        prev_idle_next     = prev_idle_reg;
        prev_slot_next     = prev_slot_reg;
        k_next             = k_reg;
        rd_valid_next      = rd_en;
        rd_idx_next        = rd_addr;
        found_next         = found_reg;
        best_next          = best_reg;
        best_idx_next      = best_idx_reg;
        out_valid_next     = out_valid_reg && !sched_out.ready;
        out_slot_next      = out_slot_reg;
        out_idle_next      = out_idle_reg;
        out_completed_next = out_completed_reg;
        out_switched_next  = out_switched_reg;
        out_all_done_next  = out_all_done_reg;
        wr_en              = 1'b0;
        wr_addr            = '0;
        wr_data            = '0;

        if (cfg_we)
        begin
            pc_next = cfg_wdata;
        end

        if (eligible)
        begin
            found_next    = 1'b1;
            best_next     = rd_data;
            best_idx_next = rd_idx_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (sched_in.action == ACT_LOAD)
                    begin
                        // Drop loads aimed past the table.
                        wr_en             = (32'(sched_in.slot) < MAX_PROCESSES);
                        wr_addr           = ADDR_W'(sched_in.slot);
                        wr_data.arrival   = sched_in.arrival_time;
                        wr_data.prio      = sched_in.priority_req;
                        wr_data.remaining = sched_in.burst_time;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        k_next     = '0;
                        state_next = (count_eff == '0) ? S_DECIDE : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                k_next = k_inc;
                if (k_inc == count_eff)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                // Hold until the result register is free.
                if (out_free)
                begin
                    wr_en             = found_reg;
                    wr_addr           = best_idx_reg;
                    wr_data.arrival   = best_reg.arrival;
                    wr_data.prio      = best_reg.prio;
                    wr_data.remaining = new_rem;

                    out_valid_next     = 1'b1;
                    out_slot_next      = found_reg ? SLOT_W'(best_idx_reg) : '0;
                    out_idle_next      = !found_reg;
                    out_completed_next = done_now;
                    out_switched_next  = found_reg
                                       ? (prev_idle_reg || (prev_slot_reg != best_idx_reg))
                                       : !prev_idle_reg;
                    out_all_done_next  = (EQ_W'(fin_upd) == EQ_W'(count_eff));

                    fin_next       = fin_upd;
                    prev_idle_next = !found_reg;
                    prev_slot_next = best_idx_reg;
                    // Advance time, saturating at its maximum; idle ticks count too.
                    if (tick_reg != '1)
                    begin
                        tick_next = tick_reg + TIME_BITS'(1);
                    end
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            pc_reg            <= '0;
            tick_reg          <= '0;
            fin_reg           <= '0;
            prev_idle_reg     <= 1'b1;
            prev_slot_reg     <= '0;
            k_reg             <= '0;
            rd_valid_reg      <= 1'b0;
            rd_idx_reg        <= '0;
            found_reg         <= 1'b0;
            best_reg          <= '0;
            best_idx_reg      <= '0;
            out_valid_reg     <= 1'b0;
            out_slot_reg      <= '0;
            out_idle_reg      <= 1'b0;
            out_completed_reg <= 1'b0;
            out_switched_reg  <= 1'b0;
            out_all_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            pc_reg            <= pc_next;
            tick_reg          <= tick_next;
            fin_reg           <= fin_next;
            prev_idle_reg     <= prev_idle_next;
            prev_slot_reg     <= prev_slot_next;
            k_reg             <= k_next;
            rd_valid_reg      <= rd_valid_next;
            rd_idx_reg        <= rd_idx_next;
            found_reg         <= found_next;
            best_reg          <= best_next;
            best_idx_reg      <= best_idx_next;
            out_valid_reg     <= out_valid_next;
            out_slot_reg      <= out_slot_next;
            out_idle_reg      <= out_idle_next;
            out_completed_reg <= out_completed_next;
            out_switched_reg  <= out_switched_next;
            out_all_done_reg  <= out_all_done_next;
        end
    end

    assign sched_out.valid       = out_valid_reg;
    assign sched_out.chosen_slot = out_slot_reg;
    assign sched_out.idle        = out_idle_reg;
    assign sched_out.completed   = out_completed_reg;
    assign sched_out.switched    = out_switched_reg;
    assign sched_out.all_done    = out_all_done_reg;

    `PPS_ASSERT_IMPLY(a_idle_beat, out_valid_reg && out_idle_reg, (out_slot_reg == '0) && !out_completed_reg, "idle beat carries a slot or completion")
    `PPS_ASSERT_IMPLY(a_wr_phase, wr_en, (state_reg == S_IDLE) || (state_reg == S_DECIDE), "table write during scan")
    `PPS_ASSERT_IMPLY(a_rd_phase, rd_valid_reg, (state_reg == S_SCAN) || (state_reg == S_DRAIN), "read data outside scan")
    `PPS_ASSERT_NEXT(a_fin_hold, state_reg != S_DECIDE, $stable(fin_reg), "finished count moved outside decide")

endmodule

[test/preemptive_priority_scheduler_tb.sv]
// Self-checking testbench for the preemptive priority scheduler.
// Depends on pps_pkg, the pps_in_if/pps_out_if channels and the scheduler RTL.
// Directed beats first, then random load/tick traffic under several stall patterns.
module preemptive_priority_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pps_pkg::*;

    localparam int MAX_SLOTS     = DEF_MAX_PROCESSES;
    localparam logic [6:0] IDLE_MARK = 7'(MAX_SLOTS);
    // Longest tick scan covers MAX_SLOTS slots; give loads and scans room to settle.
    localparam int SETTLE_CYCLES = 2 * MAX_SLOTS + 16;
    // Cycles with no beat on either channel before the run is declared hung.
    localparam int QUIET_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic                action;
        logic [SLOT_W-1:0]   slot;
        logic [ARRIVE_W-1:0] arrival;
        logic [PRIO_W-1:0]   prio;
        logic [BURST_W-1:0]  burst;
    } sched_item_t;

    localparam int ITEM_W = $bits(sched_item_t);

    typedef struct packed {
        logic [SLOT_W-1:0] chosen_slot;
        logic              idle;
        logic              completed;
        logic              switched;
        logic              all_done;
    } sched_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;

    pps_in_if  sched_in ();
    pps_out_if sched_out ();

    preemptive_priority_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sched_in  (sched_in),
        .sched_out (sched_out),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the scheduler: process table, clock, counters, register.
    logic [ARRIVE_W-1:0] arrive_tab [MAX_SLOTS];
    logic [PRIO_W-1:0]   prio_tab   [MAX_SLOTS];
    logic [BURST_W-1:0]  left_tab   [MAX_SLOTS];
    bit                  loaded     [MAX_SLOTS];
    logic [ARRIVE_W-1:0] now_tick;
    logic [FIN_W-1:0]    fin_count;
    logic [6:0]          last_served;
    logic [CFG_W-1:0]    proc_count;

    // Tick outcomes not yet seen on the result channel, oldest first.
    sched_result_t pending_ticks [$];

    int src_idle_pct;
    int snk_stall_pct;
    int mismatches;
    int n_loads, n_ticks, n_idle, n_done, n_switch, n_all_done;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver side: stall the result channel at the rate of the current phase.
    initial
    begin
        sched_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            sched_out.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Number of slots a tick actually scans: the register, clipped to the table size.
    function automatic int unsigned scan_span();
        return (proc_count > MAX_SLOTS) ? MAX_SLOTS : proc_count;
    endfunction

    // True when every slot that a tick would scan has been loaded at least once.
    function automatic bit span_loaded();
        for (int k = 0; k < scan_span(); k++)
            if (!loaded[k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void store_entry(sched_item_t it);
        arrive_tab[it.slot] = it.arrival;
        prio_tab[it.slot]   = it.prio;
        left_tab[it.slot]   = it.burst;
        loaded[it.slot]     = 1'b1;
        n_loads++;
    endfunction

    // Pick the highest-priority arrived entry with burst left (lowest slot on a tie),
    // serve it for one quantum, then advance the saturating clock.
    function automatic sched_result_t serve_tick();
        int unsigned   span;
        int unsigned   pick;
        bit            found;
        logic [7:0]    best;
        logic [6:0]    served;
        sched_result_t r;
        span  = scan_span();
        pick  = 0;
        found = 1'b0;
        best  = '0;
        r     = '0;
        for (int unsigned k = 0; k < span; k++)
        begin
            if (arrive_tab[k] <= now_tick && left_tab[k] != '0 &&
                (!found || prio_tab[k] > best))
            begin
                found = 1'b1;
                best  = prio_tab[k];
                pick  = k;
            end
        end
        if (found)
        begin
            left_tab[pick] = left_tab[pick] - 1'b1;
            if (left_tab[pick] == '0)
            begin
                r.completed = 1'b1;
                if (fin_count < FINISH_MAX)
                    fin_count = fin_count + 1'b1;
            end
            served        = 7'(pick);
            r.chosen_slot = SLOT_W'(pick);
        end
        else
        begin
            served = IDLE_MARK;
            r.idle = 1'b1;
        end
        r.switched  = (served != last_served);
        r.all_done  = (fin_count == span);
        last_served = served;
        if (now_tick != '1)
            now_tick = now_tick + 1'b1;
        n_ticks++;
        n_idle     += r.idle;
        n_done     += r.completed;
        n_switch   += r.switched;
        n_all_done += r.all_done;
        return r;
    endfunction

    // Drive one beat, hold it until the block takes it, then update the shadow model.
    // Valid stays high on exit so back-to-back beats need no extra assignment.
    task automatic send_beat(sched_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sched_in.valid <= 1'b0;
            @(posedge clk);
        end
        sched_in.valid        <= 1'b1;
        sched_in.action       <= it.action;
        sched_in.slot         <= it.slot;
        sched_in.arrival_time <= it.arrival;
        sched_in.priority_req <= it.prio;
        sched_in.burst_time   <= it.burst;
        do
            @(posedge clk);
        while (!sched_in.ready);
        if (it.action == ACT_TICK)
            pending_ticks.push_back(serve_tick());
        else
            store_entry(it);
    endtask

    task automatic send_load(int slot, int arrival, int prio, int burst);
        sched_item_t it;
        it.action  = ACT_LOAD;
        it.slot    = SLOT_W'(slot);
        it.arrival = ARRIVE_W'(arrival);
        it.prio    = PRIO_W'(prio);
        it.burst   = BURST_W'(burst);
        send_beat(it);
    endtask

    // Tick beats carry don't-care payload; randomize it so the block must ignore it.
    task automatic send_tick();
        sched_item_t it;
        it        = ITEM_W'({$urandom, $urandom});
        it.action = ACT_TICK;
        send_beat(it);
    endtask

    // Drop valid, wait for every outstanding result, then let any load in flight land.
    task automatic wait_quiet();
        sched_in.valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write process_count; only ever called with the block idle.
    task automatic write_count(int value);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
        cfg_we     <= 1'b0;
        proc_count  = CFG_W'(value);
    endtask

    // One random beat: mostly well-formed loads near the current time and ticks,
    // with ties, zero bursts, far-future arrivals and full-range values mixed in.
    task automatic random_beat();
        int span;
        int slot, arrival, prio, burst, pick;
        span = scan_span();
        if ($urandom_range(99) < 60 && span_loaded())
        begin
            send_tick();
        end
        else
        begin
            if (!span_loaded())
            begin
                slot = 0;
                while (loaded[slot])
                    slot++;
            end
            else if (span > 0 && span < MAX_SLOTS && $urandom_range(99) < 80)
                slot = $urandom_range(span - 1);
            else
                slot = $urandom_range(MAX_SLOTS - 1);
            pick = $urandom_range(99);
            if (pick < 70)
                arrival = int'(now_tick) + $urandom_range(12);
            else if (pick < 85)
                arrival = 0;
            else
                arrival = $urandom_range(16'hFFFF);
            if (arrival > 16'hFFFF)
                arrival = 16'hFFFF;
            pick = $urandom_range(99);
            if (pick < 50)
                prio = $urandom_range(3);
            else if (pick < 95)
                prio = $urandom_range(8'hFF);
            else
                prio = $urandom_range(1) ? 8'hFF : 0;
            pick = $urandom_range(99);
            if (pick < 60)
                burst = $urandom_range(1, 3);
            else if (pick < 85)
                burst = $urandom_range(4, 20);
            else if (pick < 95)
                burst = 0;
            else
                burst = $urandom_range(16'hFFFF);
            send_load(slot, arrival, prio, burst);
        end
    endtask

    // Compare each accepted result beat with the oldest predicted tick outcome.
    always @(posedge clk)
    begin : result_check
        sched_result_t got;
        sched_result_t want;
        if (rst_n && sched_out.valid && sched_out.ready)
        begin
            got.chosen_slot = sched_out.chosen_slot;
            got.idle        = sched_out.idle;
            got.completed   = sched_out.completed;
            got.switched    = sched_out.switched;
            got.all_done    = sched_out.all_done;
            if (pending_ticks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result beat with no tick outstanding: slot=%0d idle=%0b",
                             $realtime, got.chosen_slot, got.idle);
            end
            else
            begin
                want = pending_ticks.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("[%0t] tick mismatch: expected slot=%0d idle=%0b done=%0b ",
                                 $realtime, want.chosen_slot, want.idle, want.completed,
                                 "sw=%0b all=%0b, ", want.switched, want.all_done,
                                 "got slot=%0d idle=%0b done=%0b sw=%0b all=%0b",
                                 got.chosen_slot, got.idle, got.completed, got.switched,
                                 got.all_done);
                end
            end
        end
    end

    // Hang detector: any beat on either channel restarts the count.
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if ((sched_in.valid && sched_in.ready) || (sched_out.valid && sched_out.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("[%0t] no beat for %0d cycles, %0d ticks outstanding",
                     $realtime, quiet, pending_ticks.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Ticks straight out of reset: count is zero, so each idles and reports all done.
    task automatic test_idle_after_reset();
        send_tick();
        send_tick();
    endtask

    // Three slots: equal priorities resolve to the lower slot, a late high-priority
    // arrival preempts, completions and switches, then zero-burst and reload behavior.
    task automatic test_priority_and_ties();
        write_count(3);
        send_load(0, 0, 5, 2);
        send_load(1, 0, 5, 1);
        send_load(2, 4, 255, 1);
        repeat (5) send_tick();
        // Zero burst: the entry never becomes eligible and never counts as finished.
        send_load(0, 0, 200, 0);
        send_tick();
        // Reload a finished slot; its second completion is counted again.
        send_load(1, 0, 0, 1);
        send_tick();
        // Field extremes: far-future arrival, top priority, maximum burst.
        send_load(2, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_load(0, 0, 0, 16'hFFFF);
        repeat (3) send_tick();
    endtask

    // Load every slot so that any register value scans only written entries.
    task automatic test_fill_table();
        for (int k = 0; k < MAX_SLOTS; k++)
            send_load(k, $urandom_range(40), $urandom_range(8'hFF), $urandom_range(1, 6));
    endtask

    // One random phase: set the register, the idle pattern, then stream beats.
    task automatic test_random_phase(int count, int src_pct, int snk_pct, int beats);
        write_count(count);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        repeat (beats) random_beat();
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        sched_in.valid        = 1'b0;
        sched_in.action       = ACT_LOAD;
        sched_in.slot         = '0;
        sched_in.arrival_time = '0;
        sched_in.priority_req = '0;
        sched_in.burst_time   = '0;
        src_idle_pct          = 0;
        snk_stall_pct         = 0;
        mismatches            = 0;
        n_loads = 0; n_ticks = 0; n_idle = 0; n_done = 0; n_switch = 0; n_all_done = 0;
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            arrive_tab[k] = '0;
            prio_tab[k]   = '0;
            left_tab[k]   = '0;
            loaded[k]     = 1'b0;
        end
        now_tick    = '0;
        fin_count   = '0;
        last_served = IDLE_MARK;
        proc_count  = '0;

        // Hold reset, release it on a rising edge, never assert again.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_after_reset();
        test_priority_and_ties();
        test_fill_table();
        test_random_phase(MAX_SLOTS, 0, 0, 140);
        test_random_phase(127, 82, 0, 140);
        test_random_phase($urandom_range(1, 8), 0, 82, 140);
        test_random_phase($urandom_range(65, 126), 27, 27, 140);
        test_random_phase($urandom_range(2, 63), 0, 0, 140);
        test_random_phase(1, 27, 27, 20);

        // Drain, then let any stray beats settle.
        wait_quiet();
        if (pending_ticks.size() != 0)
        begin
            mismatches += pending_ticks.size();
            $display("%0d tick results never arrived", pending_ticks.size());
        end

        $display("Covered %0d loads and %0d ticks: %0d idle, %0d completions, %0d switches,",
                 n_loads, n_ticks, n_idle, n_done, n_switch);
        $display("%0d all-done ticks, clock at %0d, finished count %0d; %0d mismatches",
                 n_all_done, now_tick, fin_count, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[preemptive_priority_scheduler.f]
+incdir+hdl
hdl/pps_pkg.sv
hdl/pps_if.sv
hdl/pps_table.sv
hdl/preemptive_priority_scheduler.sv
test/preemptive_priority_scheduler_tb.sv
